// ===== design/sts_pkg.sv =====
package sts_pkg;

   // Fixed field widths of the item ports.
   localparam int CMD_W   = 2;
   localparam int VALUE_W = 32;
   localparam int POS_W   = 11;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_SEARCH = 2'd2
   } cmd_type;

   typedef enum logic {
      ST_IDLE  = 1'b0,
      ST_PROBE = 1'b1
   } state_type;

endpackage

// ===== design/sts_table_mem.sv =====
module sts_table_mem
   import sts_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024,
   localparam int ADDR_W = $clog2(TABLE_DEPTH)
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic signed [VALUE_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [ADDR_W-1:0]         rd_addr,
   output logic signed [VALUE_W-1:0] rd_data
);

   logic signed [VALUE_W-1:0] mem [TABLE_DEPTH];
   logic signed [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/sts_search_ctrl.sv =====
module sts_search_ctrl
   import sts_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024,
   localparam int ADDR_W = $clog2(TABLE_DEPTH),
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [CMD_W-1:0]          req_cmd,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      wr_en,
   output logic [ADDR_W-1:0]         wr_addr,
   output logic signed [VALUE_W-1:0] wr_data,
   output logic                      rd_en,
   output logic [ADDR_W-1:0]         rd_addr,
   input  logic signed [VALUE_W-1:0] rd_data,
   output logic                      rsp_valid,
   output logic [POS_W-1:0]          rsp_position,
   output logic                      rsp_found
);

   localparam int EXT_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          lo_ff, lo_in;
   logic [CNT_W-1:0]          hi1_ff, hi1_in;   // high bound plus one
   logic [ADDR_W-1:0]         mid_ff, mid_in;
   logic signed [VALUE_W-1:0] target_ff, target_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]          rsp_pos_ff, rsp_pos_in;
   logic                      rsp_found_ff, rsp_found_in;

   logic             accept;
   logic             is_search;
   logic             is_append;
   logic             is_clear;
   logic             table_empty;
   logic             table_full;
   logic [CNT_W-1:0] mid_ext;
   logic [CNT_W-1:0] mid_first;
   logic             cmp_lt;
   logic             cmp_eq;
   logic [CNT_W-1:0] lo_step;
   logic [CNT_W-1:0] hi1_step;
   logic [CNT_W-1:0] span_step;
   logic [CNT_W-1:0] mid_step;
   logic             miss_done;
   logic [EXT_W-1:0] pos_ext;

   assign accept      = start && (state_ff == ST_IDLE);
   assign is_search   = (req_cmd == CMD_SEARCH);
   assign is_append   = (req_cmd == CMD_APPEND);
   assign is_clear    = (req_cmd == CMD_CLEAR);
   assign table_empty = (count_ff == '0);
   assign table_full  = (count_ff == CNT_W'(TABLE_DEPTH));

   // One probe step: compare the entry just read, narrow the window, next midpoint.
   always_comb begin
      mid_ext   = CNT_W'(mid_ff);
      mid_first = (count_ff - CNT_W'(1)) >> 1;
      cmp_lt    = rd_data < target_ff;
      cmp_eq    = rd_data == target_ff;
      lo_step   = cmp_lt ? (mid_ext + CNT_W'(1)) : lo_ff;
      hi1_step  = cmp_lt ? hi1_ff : mid_ext;
      miss_done = lo_step >= hi1_step;
      span_step = hi1_step - lo_step - CNT_W'(1);
      mid_step  = lo_step + (span_step >> 1);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && is_search && !table_empty) begin
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (cmp_eq || miss_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi1_in       = hi1_ff;
      mid_in       = mid_ff;
      target_in    = target_ff;
      rsp_valid_in = 1'b0;
      rsp_pos_in   = rsp_pos_ff;
      rsp_found_in = rsp_found_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[ADDR_W-1:0];
      wr_data      = req_value;
      rd_en        = 1'b0;
      rd_addr      = mid_first[ADDR_W-1:0];
      pos_ext      = EXT_W'(lo_step);
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_clear) begin
                  count_in = '0;
               end
               if (is_append && !table_full) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
               if (is_search) begin
                  target_in = req_value;
                  lo_in     = '0;
                  hi1_in    = count_ff;
                  mid_in    = mid_first[ADDR_W-1:0];
                  if (table_empty) begin
                     rsp_valid_in = 1'b1;
                     rsp_pos_in   = '0;
                     rsp_found_in = 1'b0;
                  end else begin
                     rd_en = 1'b1;
                  end
               end
            end
         end
         ST_PROBE: begin
            if (cmp_eq) begin
               pos_ext      = EXT_W'(mid_ext);
               rsp_valid_in = 1'b1;
               rsp_pos_in   = pos_ext[POS_W-1:0];
               rsp_found_in = 1'b1;
            end else if (miss_done) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = pos_ext[POS_W-1:0];
               rsp_found_in = 1'b0;
            end else begin
               lo_in   = lo_step;
               hi1_in  = hi1_step;
               mid_in  = mid_step[ADDR_W-1:0];
               rd_en   = 1'b1;
               rd_addr = mid_step[ADDR_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi1_ff       <= hi1_in;
      mid_ff       <= mid_in;
      target_ff    <= target_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_found    = rsp_found_ff;

endmodule

// ===== design/sorted_table_insert_position_search.sv =====
// Channel   Ports                           Handshake
// request   req_cmd, req_value              start && !busy accepts one item
// response  rsp_position, rsp_found         rsp_valid, one cycle, no back-pressure
//
// Clear and append complete without raising busy, and no response is given.
// A search on an empty table is answered without probing; otherwise it makes k
// probes (at most clog2(TABLE_DEPTH + 1), so 11 at 1024) and then answers.
// Each probe is one read of the table memory, compared the cycle after the
// address goes out; the next address is formed in that same cycle.
// Synchronous active-high reset empties the table (count only, no sweep).
// The receiver cannot stall: the response is valid for exactly one cycle.
module sorted_table_insert_position_search
   import sts_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [CMD_W-1:0]          req_cmd,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   output logic [POS_W-1:0]          rsp_position,
   output logic                      rsp_found
);

   localparam int ADDR_W = $clog2(TABLE_DEPTH);

   // Memory port wiring. Writes happen only while idle and reads only while
   // searching, so a read never overlaps a write: no forwarding needed.
   logic                      wr_en;
   logic [ADDR_W-1:0]         wr_addr;
   logic signed [VALUE_W-1:0] wr_data;
   logic                      rd_en;
   logic [ADDR_W-1:0]         rd_addr;
   logic signed [VALUE_W-1:0] rd_data;

   // Control: entry count, search window, probe sequencing, response register.
   sts_search_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_cmd      (req_cmd),
      .req_value    (req_value),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .rsp_valid    (rsp_valid),
      .rsp_position (rsp_position),
      .rsp_found    (rsp_found)
   );

   // Entry storage, one write port and one registered read port.
   sts_table_mem #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

// ===== design/sts_checker.sv =====
module sts_checker
   import sts_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [CMD_W-1:0]   req_cmd,
   input logic               rsp_valid
);

   // A response only ever follows search work or a start request.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) || $past(start)))
      else $error("response without a preceding search");

   // The response shows up with the block idle again.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while still searching");

   // Clear and append finish at once and give nothing back.
   a_no_rsp_cmd: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_cmd != CMD_SEARCH)) |=> (!busy && !rsp_valid))
      else $error("non-search item left busy high or gave a response");

   // An accepted search either answers next cycle or starts probing.
   a_search_go: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_cmd == CMD_SEARCH)) |=> (busy || rsp_valid))
      else $error("search accepted but neither probing nor answered");

   // Entering the probe phase never coincides with a response.
   a_probe_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> !rsp_valid)
      else $error("response on the first probe cycle");

endmodule

bind sorted_table_insert_position_search sts_checker u_sts_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .req_cmd      (req_cmd),
   .rsp_valid    (rsp_valid)
);
